// ===== rtl/sacl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and constants for the set-associative cache
// Holds default sizes, register indexes and state codes.
// ----------------------------------------------------------------------------
package sacl_pkg;

    localparam int MAX_SETS      = 64;
    localparam int MAX_WAYS      = 8;
    localparam int MAX_RRPV_BITS = 4;
    localparam int ADDR_BITS     = 32;
    localparam int CNT_BITS      = 32;
    localparam int OUT_SET_BITS  = 6;
    localparam int OUT_WAY_BITS  = 3;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_RRPV   = 2'd1;
    localparam logic [1:0] REG_SETS   = 2'd2;
    localparam logic [1:0] REG_WAYS   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOOK,
        ST_AGE,
        ST_WRITE,
        ST_OUT,
        ST_CLEAR
    } back_state_t;

endpackage

// ===== rtl/sacl_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_if: valid/ready channel carrying one payload word
// Source drives valid and payload, sink drives ready.
// ----------------------------------------------------------------------------
interface sacl_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sacl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ram: generic single-port RAM
// One write or read per cycle; read data registered.
// ----------------------------------------------------------------------------
module sacl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/sacl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_front: address intake and set selection
// Reduce the address modulo the set count one bit per cycle, then queue it.
// ----------------------------------------------------------------------------
module sacl_front #(
    parameter int MAX_SETS  = sacl_pkg::MAX_SETS,
    parameter int ADDR_BITS = sacl_pkg::ADDR_BITS,
    localparam int SB = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [ADDR_BITS-1:0] in_addr,
    input  logic [SB:0]          sets,
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic [ADDR_BITS-1:0] q_addr,
    output logic [SB-1:0]        q_set
);
    localparam int CB = $clog2(ADDR_BITS + 1);
    localparam int IB = (ADDR_BITS > 1) ? $clog2(ADDR_BITS) : 1;

    logic                 busy_reg, busy_next;
    logic [CB-1:0]        cnt_reg, cnt_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [SB:0]          rem_reg, rem_next;
    logic [SB+1:0]        shifted;
    logic [IB-1:0]        bit_idx;
    logic                 full_reg, full_next;
    logic [ADDR_BITS-1:0] qa_reg, qa_next;
    logic [SB-1:0]        qs_reg, qs_next;

    assign in_ready = !busy_reg;
    assign q_valid  = full_reg;
    assign q_addr   = qa_reg;
    assign q_set    = qs_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        addr_next = addr_reg;
        rem_next  = rem_reg;
        full_next = full_reg;
        qa_next   = qa_reg;
        qs_next   = qs_reg;
        bit_idx   = IB'(ADDR_BITS - 1) - IB'(cnt_reg);
        shifted   = {rem_reg, addr_reg[bit_idx]};
        if (full_reg && q_ready)
        begin
            full_next = 1'b0;
        end
        if (!busy_reg)
        begin
            if (in_valid)
            begin
                busy_next = 1'b1;
                addr_next = in_addr;
                cnt_next  = '0;
                rem_next  = '0;
            end
        end
        else if (cnt_reg != CB'(ADDR_BITS))
        begin
            // restoring step: one address bit per cycle
            if (shifted >= (SB + 2)'(sets))
            begin
                rem_next = (SB + 1)'(shifted - (SB + 2)'(sets));
            end
            else
            begin
                rem_next = (SB + 1)'(shifted);
            end
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!full_next)
        begin
            full_next = 1'b1;
            qa_next   = addr_reg;
            qs_next   = SB'(rem_reg);
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            full_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            full_reg <= full_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        rem_reg  <= rem_next;
        qa_reg   <= qa_next;
        qs_reg   <= qs_next;
    end
endmodule

// ===== rtl/sacl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_back: lookup, replacement and line update
// Read one set row, search and update it, write it back, emit the result.
// ----------------------------------------------------------------------------
module sacl_back #(
    parameter int MAX_SETS      = sacl_pkg::MAX_SETS,
    parameter int MAX_WAYS      = sacl_pkg::MAX_WAYS,
    parameter int MAX_RRPV_BITS = sacl_pkg::MAX_RRPV_BITS,
    parameter int ADDR_BITS     = sacl_pkg::ADDR_BITS,
    localparam int SB = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int WB = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int GB = MAX_RRPV_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic [ADDR_BITS-1:0]         q_addr,
    input  logic [SB-1:0]                q_set,
    input  logic                         policy,
    input  logic [WB:0]                  ways,
    input  logic [GB-1:0]                rmax,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         out_hit,
    output logic [sacl_pkg::OUT_SET_BITS-1:0] out_set,
    output logic [sacl_pkg::OUT_WAY_BITS-1:0] out_way,
    output logic                         out_evicted,
    output logic [sacl_pkg::CNT_BITS-1:0] out_hits,
    output logic [sacl_pkg::CNT_BITS-1:0] out_misses
);
    localparam int CW = sacl_pkg::CNT_BITS;
    localparam int TW = MAX_WAYS * ADDR_BITS;
    localparam int AW = MAX_WAYS * GB;

    sacl_pkg::back_state_t st_reg, st_next;

    logic [SB-1:0]        clr_reg, clr_next;
    logic [SB-1:0]        ram_addr;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [SB-1:0]        set_reg, set_next;
    logic                 hit_reg, hit_next, ev_reg, ev_next;
    logic [WB-1:0]        way_reg, way_next;
    logic [CW-1:0]        hits_reg, hits_next, miss_reg, miss_next;
    logic [GB-1:0]        age_reg [MAX_WAYS];
    logic [GB-1:0]        age_next [MAX_WAYS];
    logic [MAX_WAYS-1:0]  rowv;
    logic                 ov_reg, ov_next;

    // result word, held while it waits on rsp
    logic                 oh_reg, oh_next, oe_reg, oe_next;
    logic [SB-1:0]        os_reg, os_next;
    logic [WB-1:0]        ow_reg, ow_next;
    logic [CW-1:0]        ohc_reg, ohc_next, omc_reg, omc_next;

    logic                we;
    logic [TW-1:0]       tag_rd, tag_wd;
    logic [AW-1:0]       age_rd, age_wd;
    logic [MAX_WAYS-1:0] vld_rd, vld_wd;

    assign ram_addr = (st_reg == sacl_pkg::ST_CLEAR) ? clr_reg : set_reg;

    sacl_ram #(.WIDTH(TW), .DEPTH(MAX_SETS)) u_tag (
        .clk(clk), .we(we), .addr(ram_addr), .wdata(tag_wd), .rdata(tag_rd)
    );
    sacl_ram #(.WIDTH(AW), .DEPTH(MAX_SETS)) u_age (
        .clk(clk), .we(we), .addr(ram_addr), .wdata(age_wd), .rdata(age_rd)
    );
    sacl_ram #(.WIDTH(MAX_WAYS), .DEPTH(MAX_SETS)) u_vld (
        .clk(clk), .we(we), .addr(ram_addr), .wdata(vld_wd), .rdata(vld_rd)
    );

    assign rowv        = vld_rd;
    assign q_ready     = (st_reg == sacl_pkg::ST_IDLE);
    assign out_valid   = ov_reg;
    assign out_hit     = oh_reg;
    assign out_set     = sacl_pkg::OUT_SET_BITS'(os_reg);
    assign out_way     = sacl_pkg::OUT_WAY_BITS'(ow_reg);
    assign out_evicted = oe_reg;
    assign out_hits    = ohc_reg;
    assign out_misses  = omc_reg;

    logic [WB-1:0] hit_w, inv_w, big_w, max_w;
    logic          f_hit, f_inv, f_max;
    logic [GB-1:0] big_v, top_v, rank;
    logic [WB-1:0] fw;

    always_comb
    begin
        st_next    = st_reg;
        clr_next   = clr_reg;
        addr_next  = addr_reg;
        set_next   = set_reg;
        hit_next   = hit_reg;
        ev_next    = ev_reg;
        way_next   = way_reg;
        hits_next  = hits_reg;
        miss_next  = miss_reg;
        ov_next    = ov_reg;
        oh_next    = oh_reg;
        oe_next    = oe_reg;
        os_next    = os_reg;
        ow_next    = ow_reg;
        ohc_next   = ohc_reg;
        omc_next   = omc_reg;
        age_next   = age_reg;
        we         = 1'b0;
        tag_wd     = tag_rd;
        vld_wd     = vld_rd;
        age_wd     = '0;
        f_hit = 1'b0; f_inv = 1'b0; f_max = 1'b0;
        hit_w = '0; inv_w = '0; big_w = '0; max_w = '0;
        big_v = age_reg[0]; top_v = '0; rank = '0; fw = '0;
        for (int i = 0; i < MAX_WAYS; i++)
        begin
            age_wd[i*GB +: GB] = age_reg[i];
            if (i < int'(ways))
            begin
                if (!f_hit && rowv[i] && tag_rd[i*ADDR_BITS +: ADDR_BITS] == addr_reg)
                begin
                    f_hit = 1'b1; hit_w = WB'(i);
                end
                if (!f_inv && !rowv[i])
                begin
                    f_inv = 1'b1; inv_w = WB'(i);
                end
                if (i > 0 && age_reg[i] > big_v)
                begin
                    big_v = age_reg[i]; big_w = WB'(i);
                end
                if (!f_max && age_reg[i] >= rmax)
                begin
                    f_max = 1'b1; max_w = WB'(i);
                end
                if (age_reg[i] > top_v)
                begin
                    top_v = age_reg[i];
                end
            end
        end
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (st_reg)
            sacl_pkg::ST_CLEAR:
            begin
                // zero one tag/valid/age row per cycle after reset
                we       = 1'b1;
                tag_wd   = '0;
                age_wd   = '0;
                vld_wd   = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SB'(MAX_SETS - 1))
                begin
                    st_next = sacl_pkg::ST_IDLE;
                end
            end
            sacl_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    addr_next = q_addr;
                    set_next  = q_set;
                    st_next   = sacl_pkg::ST_READ;
                end
            end
            sacl_pkg::ST_READ:
            begin
                st_next = sacl_pkg::ST_LOOK;
            end
            sacl_pkg::ST_LOOK:
            begin
                for (int i = 0; i < MAX_WAYS; i++)
                begin
                    age_next[i] = age_rd[i*GB +: GB];
                end
                st_next = sacl_pkg::ST_AGE;
            end
            sacl_pkg::ST_AGE:
            begin
                // ages registered: decide hit and victim
                ev_next = 1'b0;
                if (f_hit)
                begin
                    hit_next = 1'b1;
                    way_next = hit_w;
                    if (hits_reg != '1) hits_next = hits_reg + 1'b1;
                    st_next = sacl_pkg::ST_WRITE;
                end
                else
                begin
                    hit_next = 1'b0;
                    if (miss_reg != '1) miss_next = miss_reg + 1'b1;
                    st_next = sacl_pkg::ST_WRITE;
                    if (f_inv)
                    begin
                        way_next = inv_w;
                    end
                    else
                    begin
                        ev_next = 1'b1;
                        if (!policy)
                        begin
                            way_next = big_w;
                        end
                        else if (f_max)
                        begin
                            way_next = max_w;
                        end
                        else
                        begin
                            // raise the whole set so the top value reaches max
                            for (int i = 0; i < MAX_WAYS; i++)
                            begin
                                if (i < int'(ways))
                                begin
                                    age_next[i] = age_reg[i] + (rmax - top_v);
                                end
                            end
                            way_next = '0;
                            for (int i = MAX_WAYS - 1; i >= 0; i--)
                            begin
                                if (i < int'(ways) && age_reg[i] == top_v)
                                begin
                                    way_next = WB'(i);
                                end
                            end
                        end
                    end
                end
            end
            sacl_pkg::ST_WRITE:
            begin
                if (!ov_next)
                begin
                    fw   = way_reg;
                    rank = hit_reg ? age_reg[fw] : '1;
                    for (int i = 0; i < MAX_WAYS; i++)
                    begin
                        if (!policy && i < int'(ways) && WB'(i) != fw && rowv[i]
                            && (hit_reg ? (age_reg[i] < rank) : 1'b1)
                            && age_reg[i] != '1)
                        begin
                            age_wd[i*GB +: GB] = age_reg[i] + 1'b1;
                        end
                    end
                    if (!policy || hit_reg)
                    begin
                        age_wd[fw*GB +: GB] = '0;
                    end
                    else
                    begin
                        age_wd[fw*GB +: GB] = rmax - 1'b1;
                    end
                    if (!hit_reg)
                    begin
                        tag_wd[fw*ADDR_BITS +: ADDR_BITS] = addr_reg;
                        vld_wd[fw] = 1'b1;
                    end
                    we       = 1'b1;
                    ov_next  = 1'b1;
                    oh_next  = hit_reg;
                    oe_next  = ev_reg;
                    os_next  = set_reg;
                    ow_next  = way_reg;
                    ohc_next = hits_reg;
                    omc_next = miss_reg;
                    st_next  = sacl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                st_next = sacl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= sacl_pkg::ST_CLEAR;
            clr_reg   <= '0;
            hits_reg  <= '0;
            miss_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            clr_reg   <= clr_next;
            hits_reg  <= hits_next;
            miss_reg  <= miss_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        set_reg  <= set_next;
        hit_reg  <= hit_next;
        ev_reg   <= ev_next;
        way_reg  <= way_next;
        age_reg  <= age_next;
        oh_reg   <= oh_next;
        oe_reg   <= oe_next;
        os_reg   <= os_next;
        ow_reg   <= ow_next;
        ohc_reg  <= ohc_next;
        omc_reg  <= omc_next;
    end
endmodule

// ===== rtl/set_assoc_cache_lru_srrip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_srrip: set-associative cache with LRU or SRRIP
// Classify addresses into sets, look them up, replace and report counts.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word
//  req       in   valid/ready    address
//  rsp       out  valid/ready    hit, set_index, way_used, evicted, counts
//  apb       in   psel/penable   policy, rrpv_bits, set_count, ways_in_use
//
// Front: the bit-serial set modulo reduces the address bit by bit and queues the
// word; it takes no new address until that word is queued, and a full queue holds it.
// Back: each word passes READ, LOOK, AGE and WRITE (RAM read, age load,
// compare/victim, write back); a new word is taken only in IDLE.
// Reset clears counters and handshake state, then a pass over all MAX_SETS rows
// zeroes tag, valid and age rows. A stalled result holds the back end.
module set_assoc_cache_lru_srrip #(
    parameter int MAX_SETS      = sacl_pkg::MAX_SETS,
    parameter int MAX_WAYS      = sacl_pkg::MAX_WAYS,
    parameter int MAX_RRPV_BITS = sacl_pkg::MAX_RRPV_BITS,
    parameter int ADDR_BITS     = sacl_pkg::ADDR_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    sacl_if.sink        req,
    sacl_if.source      rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int SB = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WB = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int GB = MAX_RRPV_BITS;

    logic       policy_reg;
    logic [2:0] rrpv_reg;
    logic [6:0] sets_reg;
    logic [3:0] ways_reg;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b0;
            rrpv_reg   <= 3'd2;
            sets_reg   <= 7'd64;
            ways_reg   <= 4'd8;
        end
        else if (psel && penable && pwrite)
        begin
            case (idx)
                sacl_pkg::REG_POLICY: policy_reg <= pwdata[0];
                sacl_pkg::REG_RRPV:   rrpv_reg   <= pwdata[2:0];
                sacl_pkg::REG_SETS:   sets_reg   <= pwdata[6:0];
                sacl_pkg::REG_WAYS:   ways_reg   <= pwdata[3:0];
                default:              policy_reg <= policy_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            sacl_pkg::REG_POLICY: prdata = {31'd0, policy_reg};
            sacl_pkg::REG_RRPV:   prdata = {29'd0, rrpv_reg};
            sacl_pkg::REG_SETS:   prdata = {25'd0, sets_reg};
            sacl_pkg::REG_WAYS:   prdata = {28'd0, ways_reg};
            default:              prdata = '0;
        endcase
    end

    // clamp zero to one and saturate at the built sizes
    logic [SB:0]   sets_eff;
    logic [WB:0]   ways_eff;
    logic [GB-1:0] rmax;
    logic [3:0]    mbits;
    always_comb
    begin
        if (sets_reg == '0) sets_eff = (SB + 1)'(1);
        else if (32'(sets_reg) > MAX_SETS) sets_eff = (SB + 1)'(MAX_SETS);
        else sets_eff = (SB + 1)'(sets_reg);
        if (ways_reg == '0) ways_eff = (WB + 1)'(1);
        else if (32'(ways_reg) > MAX_WAYS) ways_eff = (WB + 1)'(MAX_WAYS);
        else ways_eff = (WB + 1)'(ways_reg);
        if (rrpv_reg == '0) mbits = 4'd1;
        else if (32'(rrpv_reg) > MAX_RRPV_BITS) mbits = 4'(MAX_RRPV_BITS);
        else mbits = 4'(rrpv_reg);
        rmax = GB'((32'd1 << mbits) - 32'd1);
    end

    logic                 q_valid, q_ready;
    logic [ADDR_BITS-1:0] q_addr;
    logic [SB-1:0]        q_set;

    sacl_front #(.MAX_SETS(MAX_SETS), .ADDR_BITS(ADDR_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(req.valid), .in_ready(req.ready), .in_addr(req.data),
        .sets(sets_eff),
        .q_valid(q_valid), .q_ready(q_ready), .q_addr(q_addr), .q_set(q_set)
    );

    sacl_back #(
        .MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS),
        .MAX_RRPV_BITS(MAX_RRPV_BITS), .ADDR_BITS(ADDR_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_addr(q_addr), .q_set(q_set),
        .policy(policy_reg), .ways(ways_eff), .rmax(rmax),
        .out_valid(rsp.valid), .out_ready(rsp.ready),
        .out_hit(rsp.data.hit), .out_set(rsp.data.set_index),
        .out_way(rsp.data.way_used), .out_evicted(rsp.data.evicted),
        .out_hits(rsp.data.hit_count), .out_misses(rsp.data.miss_count)
    );
endmodule
